@@ src/atrts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package atrts_pkg;

  localparam int TermDepthDefault = 64;
  localparam int QueueDepthDefault = 4;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // work handed from the classifier to the term engine
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STORE = 2'd1,
    OP_CLOSE = 2'd2
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
  } entry_t;

endpackage

`default_nettype wire

@@ src/atrts_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module atrts_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [7:0]        ch,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   push_valid,
  output atrts_pkg::entry_t      push_entry,
  input  wire logic              push_ready
);

  logic in_response, in_response_next;
  logic in_command_term, in_command_term_next;
  logic do_push;
  atrts_pkg::op_t op;
  logic accept;

  // only accept while the queue has room, even for bytes that are dropped
  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    do_push = 1'b0;
    op = atrts_pkg::OP_STORE;
    in_response_next = in_response;
    in_command_term_next = in_command_term;
    if (ch == atrts_pkg::CH_PLUS) begin
      do_push = 1'b1;
      op = atrts_pkg::OP_START;
      in_response_next = 1'b1;
      in_command_term_next = 1'b1;
    end else if (!in_response) begin
      do_push = 1'b0;
    end else if (ch == atrts_pkg::CH_CR || ch == atrts_pkg::CH_LF) begin
      do_push = 1'b1;
      op = atrts_pkg::OP_CLOSE;
      in_response_next = 1'b0;
      in_command_term_next = 1'b0;
    end else if (ch == atrts_pkg::CH_COMMA || ch == atrts_pkg::CH_COLON) begin
      do_push = 1'b1;
      op = atrts_pkg::OP_CLOSE;
      in_command_term_next = 1'b0;
    end else if (ch == atrts_pkg::CH_SPACE) begin
      do_push = in_command_term;
    end else begin
      do_push = 1'b1;
    end
  end

  assign push_valid    = in_valid && do_push;
  assign push_entry.op = op;
  assign push_entry.ch = ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_response <= 1'b0;
      in_command_term <= 1'b0;
    end else if (accept) begin
      in_response <= in_response_next;
      in_command_term <= in_command_term_next;
    end
  end

endmodule

`default_nettype wire

@@ src/atrts_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module atrts_queue #(
  parameter int DEPTH = atrts_pkg::QueueDepthDefault
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  input  wire atrts_pkg::entry_t push_entry,
  output logic                   push_ready,
  output logic                   pop_valid,
  output atrts_pkg::entry_t      pop_entry,
  input  wire logic              pop_ready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [CW-1:0] Full = CW'(DEPTH);

  atrts_pkg::entry_t slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic push, pop;

  assign push_ready = (count != Full);
  assign pop_valid  = (count != '0);
  assign pop_entry  = slots[rd_ptr];
  assign push = push_valid && push_ready;
  assign pop  = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastIdx) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastIdx) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ src/atrts_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module atrts_back #(
  parameter int TERM_DEPTH = atrts_pkg::TermDepthDefault
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              pop_valid,
  input  wire atrts_pkg::entry_t pop_entry,
  output logic                   pop_ready,
  output logic [7:0]             term_char,
  output logic                   char_valid,
  output logic                   last,
  output logic [15:0]            term_number,
  output logic                   truncated,
  output logic                   out_valid,
  input  wire logic              out_ready
);

  localparam int LW = $clog2(TERM_DEPTH + 1);
  localparam int AW = $clog2(TERM_DEPTH);
  localparam logic [LW-1:0] Full = LW'(TERM_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_OUT  = 2'b10
  } state_t;

  state_t state, state_next;

  logic [7:0] term_buffer [TERM_DEPTH];
  logic [7:0] rd_data;

  logic [LW-1:0] length, length_next;
  logic [LW-1:0] rd_idx, rd_idx_next;
  logic [LW-1:0] close_len, close_len_next;
  logic [15:0]   total, total_next;
  logic          overflowed, overflowed_next;
  logic          cv, cv_next;
  logic          last_q, last_next;
  logic          trunc, trunc_next;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  always_comb begin
    state_next = state;
    length_next = length;
    rd_idx_next = rd_idx;
    close_len_next = close_len;
    total_next = total;
    overflowed_next = overflowed;
    cv_next = cv;
    last_next = last_q;
    trunc_next = trunc;
    wr_en = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    rd_en = 1'b0;
    rd_addr = '0;
    pop_ready = 1'b0;
    case (state)
      S_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          case (pop_entry.op)
            atrts_pkg::OP_START: begin
              wr_en = 1'b1;
              wr_addr = '0;
              wr_data = atrts_pkg::CH_PLUS;
              length_next = LW'(1);
              overflowed_next = 1'b0;
            end
            atrts_pkg::OP_STORE: begin
              if (length < Full) begin
                wr_en = 1'b1;
                wr_addr = length[AW-1:0];
                wr_data = pop_entry.ch;
                length_next = length + LW'(1);
              end else begin
                overflowed_next = 1'b1;
              end
            end
            atrts_pkg::OP_CLOSE: begin
              total_next = total + 16'd1;
              trunc_next = overflowed;
              close_len_next = length;
              length_next = '0;
              overflowed_next = 1'b0;
              state_next = S_OUT;
              if (length == '0) begin
                cv_next = 1'b0;
                last_next = 1'b1;
              end else begin
                // first character read now, shows up with out_valid
                cv_next = 1'b1;
                last_next = (length == LW'(1));
                rd_en = 1'b1;
                rd_addr = '0;
                rd_idx_next = LW'(1);
              end
            end
            default: ;
          endcase
        end
      end
      S_OUT: begin
        if (out_ready) begin
          if (last_q) begin
            state_next = S_IDLE;
          end else begin
            rd_en = 1'b1;
            rd_addr = rd_idx[AW-1:0];
            rd_idx_next = rd_idx + LW'(1);
            last_next = ((rd_idx + LW'(1)) == close_len);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      term_buffer[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= term_buffer[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      length <= '0;
      total <= '0;
      overflowed <= 1'b0;
    end else begin
      state <= state_next;
      length <= length_next;
      total <= total_next;
      overflowed <= overflowed_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= rd_idx_next;
    close_len <= close_len_next;
    cv <= cv_next;
    last_q <= last_next;
    trunc <= trunc_next;
  end

  assign out_valid   = (state == S_OUT);
  assign term_char   = cv ? rd_data : 8'h00;
  assign char_valid  = cv;
  assign last        = last_q;
  assign term_number = total;
  assign truncated   = trunc;

endmodule

`default_nettype wire

@@ src/at_response_term_splitter_top.sv @@
// AT response term splitter.
// Input: one response byte per transaction on ch / in_valid / in_ready.
// Output: term items on term_char, char_valid, last, term_number, truncated
// with out_valid / out_ready. A term of N stored characters comes out as N
// items, the final one with last set; an empty term is one item with
// char_valid low and last set. Characters past TERM_DEPTH are dropped and
// the term is flagged truncated on all its items.
// A classifier takes one byte per cycle into a small queue (QUEUE_DEPTH
// entries); in_ready drops only when that queue is full. The term engine
// takes one queue entry per cycle while idle; during a term's readout it
// takes none, reading the buffer once per item, and then returns to idle.
// While out_ready is low the current item holds and the engine waits;
// the queue keeps absorbing bytes until it fills.
// rst (synchronous) clears the response state, term count and queue; the
// term buffer is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module at_response_term_splitter_top #(
  parameter int TERM_DEPTH  = atrts_pkg::TermDepthDefault,
  parameter int QUEUE_DEPTH = atrts_pkg::QueueDepthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  ch,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic [7:0]       term_char,
  output logic             char_valid,
  output logic             last,
  output logic [15:0]      term_number,
  output logic             truncated,
  output logic             out_valid,
  input  wire logic        out_ready
);

  logic              push_valid, push_ready;
  atrts_pkg::entry_t push_entry;
  logic              pop_valid, pop_ready;
  atrts_pkg::entry_t pop_entry;

  atrts_front u_front (
    .clk        (clk),
    .rst        (rst),
    .ch         (ch),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  atrts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop_ready  (pop_ready)
  );

  atrts_back #(
    .TERM_DEPTH (TERM_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_entry   (pop_entry),
    .pop_ready   (pop_ready),
    .term_char   (term_char),
    .char_valid  (char_valid),
    .last        (last),
    .term_number (term_number),
    .truncated   (truncated),
    .out_valid   (out_valid),
    .out_ready   (out_ready)
  );

  // an empty term is always a single item
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !char_valid |-> last)
    else $error("empty term item without last");

  // within a term the next item follows at once with the same number
  a_term_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && $stable(term_number))
    else $error("term readout broke or term number moved");

  // no item is shown right after the last item of a term; the engine first returns to idle
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> !out_valid)
    else $error("item shown right after the last of a term");

endmodule

`default_nettype wire
